FILE: hdl/qtt_pkg.sv
// shared types, character codes and the result append helper for the quoted text tokenizer
package qtt_pkg;

  localparam int MaxResults = 4;
  localparam int CntW       = $clog2(MaxResults + 1);
  localparam int IdxW       = $clog2(MaxResults);
  localparam int QueueDepth = 4;

  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLess   = 8'h3C;
  localparam logic [7:0] ChGreat  = 8'h3E;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChSQuote = 8'h27;
  localparam logic [7:0] ChDQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_END   = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] token_char;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } result_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [CntW-1:0]                cnt;
    result_t [MaxResults-1:0]       res;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } bundle_xfer_t;

  function automatic bundle_t push_res(bundle_t b, kind_t k, logic [7:0] ch);
    bundle_t r;
    r = b;
    r.res[b.cnt[IdxW-1:0]] = '{kind: k, ch: ch};
    r.cnt = b.cnt + CntW'(1);
    return r;
  endfunction

endpackage

FILE: hdl/qtt_front.sv
// front end: classifies each byte, keeps lexer state, builds the result bundle
module qtt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic              byte_stall,
  input  qtt_pkg::in_item_t byte_item,
  output qtt_pkg::bundle_xfer_t push
);
  import qtt_pkg::*;

  logic in_quote, quote_is_double, escape_pending, operator_pending, token_open;
  logic in_quote_next, quote_is_double_next, escape_pending_next;
  logic operator_pending_next, token_open_next;
  bundle_t bundle;
  logic accept;

  assign accept = byte_valid && !byte_stall;

  always_comb begin
    logic [7:0] c;
    logic       eol;
    logic       handled;
    logic       is_space;
    c        = byte_item.char_code;
    eol      = byte_item.end_of_line;
    handled  = 1'b0;
    bundle   = '0;
    is_space = ((c >= ChTab) && (c <= ChCr)) || (c == ChSpace) || (c == ChSemi);
    in_quote_next         = in_quote;
    quote_is_double_next  = quote_is_double;
    escape_pending_next   = escape_pending;
    operator_pending_next = operator_pending;
    token_open_next       = token_open;

    // pending operator: absorb one '=' or close the operator token
    if (operator_pending) begin
      operator_pending_next = 1'b0;
      if (c == ChEq) begin
        bundle = push_res(bundle, KIND_CHAR, c);
        bundle = push_res(bundle, KIND_END, 8'h00);
        token_open_next = 1'b0;
        handled = 1'b1;
      end else if (token_open_next) begin
        bundle = push_res(bundle, KIND_END, 8'h00);
        token_open_next = 1'b0;
      end
    end

    if (!handled) begin
      if (in_quote) begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          bundle = push_res(bundle, KIND_CHAR, c);
          token_open_next = 1'b1;
        end else if (c == (quote_is_double ? ChDQuote : ChSQuote)) begin
          in_quote_next = 1'b0;
        end else if ((c == ChBslash) && !eol) begin
          escape_pending_next = 1'b1;
        end else begin
          bundle = push_res(bundle, KIND_CHAR, c);
          token_open_next = 1'b1;
        end
      end else if ((c == ChSQuote) || (c == ChDQuote)) begin
        in_quote_next        = 1'b1;
        quote_is_double_next = (c == ChDQuote);
      end else if (is_space) begin
        if (token_open_next) begin
          bundle = push_res(bundle, KIND_END, 8'h00);
          token_open_next = 1'b0;
        end
      end else if ((c == ChComma) || (c == ChLParen) || (c == ChRParen)) begin
        if (token_open_next) begin
          bundle = push_res(bundle, KIND_END, 8'h00);
        end
        bundle = push_res(bundle, KIND_CHAR, c);
        bundle = push_res(bundle, KIND_END, 8'h00);
        token_open_next = 1'b0;
      end else if ((c == ChLess) || (c == ChGreat) || (c == ChBang) || (c == ChEq)) begin
        if (token_open_next) begin
          bundle = push_res(bundle, KIND_END, 8'h00);
        end
        bundle = push_res(bundle, KIND_CHAR, c);
        token_open_next       = 1'b1;
        operator_pending_next = 1'b1;
      end else begin
        bundle = push_res(bundle, KIND_CHAR, c);
        token_open_next = 1'b1;
      end
    end

    // end of line: error inside quotes, else close token and report done
    if (eol) begin
      if (in_quote_next) begin
        bundle = push_res(bundle, KIND_ERROR, 8'h00);
      end else begin
        if (token_open_next) begin
          bundle = push_res(bundle, KIND_END, 8'h00);
        end
        bundle = push_res(bundle, KIND_DONE, 8'h00);
      end
      in_quote_next         = 1'b0;
      quote_is_double_next  = 1'b0;
      escape_pending_next   = 1'b0;
      operator_pending_next = 1'b0;
      token_open_next       = 1'b0;
    end
  end

  assign push = '{valid: accept && (bundle.cnt != '0), bundle: bundle};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote         <= 1'b0;
      quote_is_double  <= 1'b0;
      escape_pending   <= 1'b0;
      operator_pending <= 1'b0;
      token_open       <= 1'b0;
    end else if (accept) begin
      in_quote         <= in_quote_next;
      quote_is_double  <= quote_is_double_next;
      escape_pending   <= escape_pending_next;
      operator_pending <= operator_pending_next;
      token_open       <= token_open_next;
    end
  end

endmodule

FILE: hdl/qtt_queue.sv
// small bundle queue between front end and back end
module qtt_queue #(
  parameter int QUEUE_DEPTH = qtt_pkg::QueueDepth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  qtt_pkg::bundle_xfer_t push,
  input  logic                  pop,
  output qtt_pkg::bundle_xfer_t head,
  output logic                  full
);
  import qtt_pkg::*;

  localparam int PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CountW = $clog2(QUEUE_DEPTH + 1);

  bundle_t mem [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CountW-1:0] count;
  logic              do_push, do_pop;

  assign full    = (count == CountW'(QUEUE_DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count != '0);

  assign head = '{valid: (count != '0), bundle: mem[rd_ptr]};

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CountW'(1);
        2'b01:   count <= count - CountW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/qtt_back.sv
// back end: walks the head bundle one result per cycle, unless result_stall holds the output, into the output register
module qtt_back (
  input  logic                  clk,
  input  logic                  rst,
  input  qtt_pkg::bundle_xfer_t head,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output qtt_pkg::out_item_t    result_item
);
  import qtt_pkg::*;

  logic [IdxW-1:0] idx;
  logic            load, last;

  assign load = head.valid && (!result_valid || !result_stall);
  assign last = ((CntW'(idx) + CntW'(1)) == head.bundle.cnt);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= head.valid;
      if (head.valid) begin
        idx <= last ? '0 : idx + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_item.kind       <= head.bundle.res[idx].kind;
      result_item.token_char <= head.bundle.res[idx].ch;
      result_item.run_last   <= last;
    end
  end

endmodule

FILE: hdl/quoted_text_tokenizer_unit.sv
// top level of the quoted text tokenizer: front end, bundle queue, back end
//
//  channel  direction  handshake                   payload
//  byte     in         byte_valid / byte_stall     in_item_t  {char_code, end_of_line}
//  result   out        result_valid / result_stall out_item_t {kind, token_char, run_last}
//
// one byte is taken every cycle while the queue has room; the front end does
// all classification for a byte in that cycle and hands its results, up to four,
// over as one bundle; a byte with no results pushes nothing
// the back end sends one result per cycle while result_stall is low, so the results of
// a byte leave one after another; QUEUE_DEPTH bundles soak up such bursts
// the first result of a byte is registered twice before it is presented: first as a
// queue entry, then in the back end's output register
// rst (synchronous) clears lexer state, queue pointers and output valid
// byte_stall is high only when the queue is full; a stalled result holds
module quoted_text_tokenizer_unit #(
  parameter int QUEUE_DEPTH = qtt_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  qtt_pkg::in_item_t  byte_item,
  output logic               result_valid,
  input  logic               result_stall,
  output qtt_pkg::out_item_t result_item
);
  import qtt_pkg::*;

  bundle_xfer_t push;   // bundle from the front end, valid only if non-empty
  bundle_xfer_t head;   // oldest queued bundle
  logic         pop;    // back end has sent the last result of the head bundle
  logic         full;

  // the front end stalls only on a full queue
  assign byte_stall = full;

  qtt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .push       (push)
  );

  qtt_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (full)
  );

  qtt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule
